FILE: design/bpfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
package bpfa_pkg;

    localparam int PageTotalDef = 4096;
    localparam int WordBits     = 64;

    typedef enum logic [1:0] {
        FN_RESERVE   = 2'd0,
        FN_ALLOC_ONE = 2'd1,
        FN_ALLOC_RUN = 2'd2,
        FN_FREE      = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] page_index;
        logic [12:0] run_length;
    } t_req;

    typedef struct packed {
        logic [11:0] result_page;
        logic        status;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture request, clear scan state
        logic rd;        // issue read of the word at the datapath's read address
        logic scan;      // evaluate read data for the active search
        logic mark;      // read-modify-write of current word
        logic adv;       // step word pointer
        logic fail;      // finish with status 1
        logic done;      // present result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic last_word;
        logic found;     // search hit on the evaluated word
        logic mark_last; // marking has covered its final word
        logic bad_len;   // run request with invalid length
        logic skip;      // reserve/free with nothing to touch
        logic direct;    // reserve/free: go straight to marking
    } t_sts;

endpackage

FILE: design/bitmap_page_frame_allocator_core.sv
// Top level of the bitmap first-fit page frame allocator.
//
//  channel   | ports                         | timing
//  ----------+-------------------------------+------------------------------
//  request   | i_start, o_busy, i_req        | transfer when start & !busy
//  result    | o_valid, o_rsp                | one-cycle strobe, no stall
//
// Steps: reserve/free go from a check state to marking, a read and a write
// state per touched 64-page word, then strobe their result (straight to the
// result when nothing is touched; a bad run length fails at once); allocation
// scans the map word by word, a read and an evaluate state per word (memory
// read latency), then marks likewise. The receiver cannot stall. Reset clears
// control at once, then a pass zeroes the map; busy stays high until it ends.
module bitmap_page_frame_allocator_core #(
    parameter int PAGE_TOTAL = bpfa_pkg::PageTotalDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bpfa_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_valid,
    output bpfa_pkg::t_rsp o_rsp
);
    import bpfa_pkg::*;

    t_cmd cmd, cmd_g;
    t_sts sts;
    logic fsm_busy;
    logic clr_busy;

    // Hold off requests during the clearing pass.
    logic start_g;
    assign start_g = i_start & ~clr_busy;

    bpfa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start_g),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (fsm_busy)
    );

    // Suppress marking writes while clearing.
    always_comb begin
        cmd_g = cmd;
        if (clr_busy) begin
            cmd_g.mark = 1'b0;
        end
    end

    bpfa_dpath #(.PAGE_TOTAL(PAGE_TOTAL)) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_cmd     (cmd_g),
        .o_sts     (sts),
        .o_rsp     (o_rsp),
        .o_done    (o_valid),
        .o_clr_busy(clr_busy)
    );

    assign o_busy = fsm_busy | clr_busy;

endmodule

FILE: design/bpfa_ctrl.sv
// Controller state machine for the bitmap page frame allocator.
module bpfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bpfa_pkg::t_sts i_sts,
    output bpfa_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import bpfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_RD, S_EVAL, S_MRD, S_MWR, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.bad_len) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else if (i_sts.skip) begin
                    n_state = S_DONE;
                end else if (i_sts.direct) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_MRD;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_RD: n_state = S_EVAL;
            S_EVAL: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_MRD;
                end else if (i_sts.last_word) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                    o_cmd.rd  = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_MRD: n_state = S_MWR;
            S_MWR: begin
                o_cmd.mark = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                    o_cmd.rd  = 1'b1;
                    n_state   = S_MRD;
                end
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: design/bpfa_dpath.sv
// Datapath of the allocator: used map memory, run search and marking.
module bpfa_dpath #(
    parameter int PAGE_TOTAL = bpfa_pkg::PageTotalDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpfa_pkg::t_req  i_req,
    input  bpfa_pkg::t_cmd  i_cmd,
    output bpfa_pkg::t_sts  o_sts,
    output bpfa_pkg::t_rsp  o_rsp,
    output logic            o_done,
    output logic            o_clr_busy
);
    import bpfa_pkg::*;

    localparam int WordCnt = (PAGE_TOTAL + WordBits - 1) / WordBits;
    localparam int WW      = (WordCnt > 1) ? $clog2(WordCnt) : 1;
    localparam int PW      = ($clog2(PAGE_TOTAL + 1) > 13) ? $clog2(PAGE_TOTAL + 1) : 13;
    localparam int BW      = $clog2(WordBits);

    logic [WordBits-1:0] r_mem [WordCnt];
    logic [WordBits-1:0] r_rdata;

    // Clearing pass after reset.
    logic [WW:0] r_clr;
    assign o_clr_busy = (r_clr != WordCnt[WW:0]);

    logic [1:0]    r_func;
    logic [PW-1:0] r_len;       // pages requested (run)
    logic [WW-1:0] r_wptr;
    logic [PW-1:0] r_run;       // free run length so far
    logic [PW-1:0] r_lo;        // first page to mark
    logic [PW-1:0] r_hi;        // one past last page to mark
    logic          r_status;
    logic [11:0]   r_res;
    logic          r_done;

    logic [PW-1:0] req_idx;
    logic [PW:0]   req_end;
    assign req_idx = PW'(i_req.page_index);

    // Page base of current word.
    logic [PW-1:0] wbase;
    assign wbase = PW'({r_wptr, {BW{1'b0}}});

    // Used bits of current word (pages beyond map read as used).
    logic [WordBits-1:0] used_w;
    always_comb begin
        for (int b = 0; b < WordBits; b++) begin
            used_w[b] = r_rdata[b] | ((PW+1)'(wbase) + (PW+1)'(b) >= (PW+1)'(PAGE_TOTAL));
        end
    end

    // Lowest free bit of the word for single allocation.
    logic          one_hit;
    logic [BW-1:0] one_pos;
    always_comb begin
        one_hit = 1'b0;
        one_pos = '0;
        for (int b = WordBits - 1; b >= 0; b--) begin
            if (!used_w[b]) begin
                one_hit = 1'b1;
                one_pos = BW'(b);
            end
        end
    end

    // Run search: free run ending at each bit, from the nearest used bit below
    // it or, with none, carried on from the previous words. Each bit is
    // evaluated in parallel; the lowest bit whose run reaches r_len wins.
    logic          run_hit;
    logic [BW-1:0] run_pos;
    logic [PW-1:0] run_out;
    logic [PW:0]   run_cnt [WordBits];
    always_comb begin
        logic          seen;
        logic [BW-1:0] last;
        for (int b = 0; b < WordBits; b++) begin
            seen = 1'b0;
            last = '0;
            for (int j = 0; j < b; j++) begin
                if (used_w[j]) begin
                    seen = 1'b1;
                    last = BW'(j);
                end
            end
            if (used_w[b])  run_cnt[b] = '0;
            else if (seen)  run_cnt[b] = (PW+1)'(b) - (PW+1)'(last);
            else            run_cnt[b] = (PW+1)'(r_run) + (PW+1)'(b) + 1'b1;
        end
    end

    always_comb begin
        run_hit = 1'b0;
        run_pos = '0;
        for (int b = WordBits - 1; b >= 0; b--) begin
            if (!used_w[b] && run_cnt[b] >= (PW+1)'(r_len)) begin
                run_hit = 1'b1;
                run_pos = BW'(b);
            end
        end
        run_out = PW'(run_cnt[WordBits-1]);
    end

    logic [PW-1:0] hit_page;
    assign hit_page = wbase + PW'((r_func == FN_ALLOC_ONE) ? one_pos : run_pos);

    // First page of the granted block.
    logic [PW-1:0] hit_lo;
    assign hit_lo = (r_func == FN_ALLOC_ONE) ? hit_page : hit_page + 1'b1 - r_len;

    assign o_sts.last_word = (r_wptr == WW'(WordCnt - 1));
    assign o_sts.found     = (r_func == FN_ALLOC_ONE) ? one_hit : run_hit;
    assign o_sts.mark_last = ((PW+1)'(wbase) + (PW+1)'(WordBits) >= (PW+1)'(r_hi));
    assign o_sts.bad_len   = (r_func == FN_ALLOC_RUN) &&
                             (r_len == '0 || (PW+1)'(r_len) > (PW+1)'(PAGE_TOTAL));
    assign o_sts.skip      = (r_func == FN_FREE || r_func == FN_RESERVE) && (r_hi <= r_lo);
    assign o_sts.direct    = (r_func == FN_FREE || r_func == FN_RESERVE);

    // Word address of the next read: on a hit, jump to the first word to mark.
    logic [WW-1:0] rd_addr;
    always_comb begin
        if (i_cmd.scan && o_sts.found) rd_addr = WW'(hit_lo >> BW);
        else if (i_cmd.adv)            rd_addr = r_wptr + 1'b1;
        else                           rd_addr = r_wptr;
    end

    // Mark/clear mask over current word.
    logic [WordBits-1:0] mask;
    always_comb begin
        for (int b = 0; b < WordBits; b++) begin
            mask[b] = ((PW+1)'(wbase) + (PW+1)'(b) >= (PW+1)'(r_lo)) &&
                      ((PW+1)'(wbase) + (PW+1)'(b) <  (PW+1)'(r_hi));
        end
    end

    always_comb begin
        logic [PW+13:0] e;
        e = (PW+14)'(req_idx) + (PW+14)'(i_req.run_length);
        if (e > (PW+14)'(PAGE_TOTAL)) req_end = (PW+1)'(PAGE_TOTAL);
        else                          req_end = (PW+1)'(e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
            if (o_clr_busy) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_clr_busy) begin
            r_mem[r_clr[WW-1:0]] <= '0;
        end else if (i_cmd.mark) begin
            if (r_func == FN_FREE) r_mem[r_wptr] <= r_rdata & ~mask;
            else                   r_mem[r_wptr] <= r_rdata | mask;
        end
        if (i_cmd.rd) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_req.func;
            r_len    <= ((PW+1)'(i_req.run_length) > (PW+1)'(PAGE_TOTAL)) ?
                        '0 : PW'(i_req.run_length);
            r_run    <= '0;
            r_status <= 1'b0;
            r_res    <= '0;
            if (i_req.func == FN_FREE) begin
                r_lo   <= req_idx;
                r_hi   <= ((PW+1)'(req_idx) < (PW+1)'(PAGE_TOTAL)) ? req_idx + 1'b1 : req_idx;
                r_wptr <= WW'(req_idx >> BW);
            end else if (i_req.func == FN_RESERVE) begin
                r_lo   <= req_idx;
                r_hi   <= (req_end > (PW+1)'(req_idx)) ? PW'(req_end) : req_idx;
                r_wptr <= WW'(req_idx >> BW);
            end else begin
                r_lo   <= '0;
                r_hi   <= '0;
                r_wptr <= '0;
            end
            if (i_req.func == FN_ALLOC_RUN &&
                (PW+1)'(i_req.run_length) > (PW+1)'(PAGE_TOTAL))
                r_func <= FN_ALLOC_RUN;
        end else begin
            if (i_cmd.load == 1'b0 && i_cmd.scan) begin
                r_run <= run_out;
                if (o_sts.found) begin
                    r_lo   <= hit_lo;
                    r_hi   <= hit_page + 1'b1;
                    r_res  <= 12'(hit_lo);
                    r_wptr <= WW'(hit_lo >> BW);
                end
            end
            if (i_cmd.adv) r_wptr <= r_wptr + 1'b1;
            if (i_cmd.fail) begin
                r_status <= 1'b1;
                r_res    <= '0;
            end
        end
    end

    assign o_rsp.result_page = r_res;
    assign o_rsp.status      = r_status;
    assign o_done            = r_done;

endmodule
